### hw/rtl/aro_pkg.sv
// aro_pkg: widths, range levels, status codes and state encoding for the
// autoranging ohmmeter; no dependencies, compiled first
package aro_pkg;

  localparam int LEVELS    = 5;                    // calibrated range levels
  localparam int LVL_W     = $clog2(LEVELS);       // bits to index a level
  localparam int LVL_FW    = 3;                    // level field width
  localparam int SAMPLE_W  = 24;                   // signed converter word
  localparam int UV_W      = 23;                   // clamped microvolts
  localparam int OHM_W     = 31;                   // reference ohms
  localparam int PROD_W    = OHM_W + UV_W;         // ohms times microvolts
  localparam int OHMS_W    = 63;                   // result ohms
  localparam int MCNT_W    = $clog2(UV_W + 1);
  localparam int DCNT_W    = $clog2(PROD_W + 1);

  localparam logic [UV_W-1:0]   THR_RESET = UV_W'(125000);
  localparam logic [OHMS_W-1:0] OHMS_MAX  = {OHMS_W{1'b1}};

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_BAD  = 3'd1,
    ST_NEG  = 3'd2,
    ST_CONV = 3'd3,
    ST_NEXT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

### hw/rtl/aro_if.sv
// aro_if: valid/ready channels for readings and results
// depends on aro_pkg
interface aro_in_if;
  import aro_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [SAMPLE_W-1:0] sample_uv;
  logic                sample_overrange;
  logic                sample_error;
  logic [LVL_FW-1:0]   cal_level;
  logic [OHM_W-1:0]    ref_ohms;

  modport source (output valid, mode, sample_uv, sample_overrange, sample_error,
                  cal_level, ref_ohms, input ready);
  modport sink   (input valid, mode, sample_uv, sample_overrange, sample_error,
                  cal_level, ref_ohms, output ready);
endinterface

interface aro_out_if;
  import aro_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [LVL_FW-1:0] range_level;
  logic [OHMS_W-1:0] ohms;
  logic [UV_W-1:0]   stored_uv;

  modport source (output valid, status, range_level, ohms, stored_uv, input ready);
  modport sink   (input valid, status, range_level, ohms, stored_uv, output ready);
endinterface

### hw/rtl/autorange_ohmmeter_calibrated.sv
// autorange_ohmmeter_calibrated: range walk, calibration table and ratio
// result; depends on aro_pkg, aro_if, aro_mul and aro_div
//
//   channel  dir  handshake          word
//   in_ch    in   valid/ready        mode, sample_uv, overrange, error, cal_level, ref_ohms
//   out_ch   out  valid/ready        status, range_level, ohms, stored_uv
//   cfg_*    in   cfg_we, no ready   range threshold in microvolts
//
// one word at a time: a walk-ending word with a usable calibration passes
// through the serial multiply and then the serial divide before its result
// is queued; any other word goes from the accept straight to the output hop
// reset is synchronous and restores level 0, an empty calibration table and
// the default threshold; a held result stalls only the next finished word,
// the input is free again as soon as a result is queued
module autorange_ohmmeter_calibrated (
  input  logic                     clk,
  input  logic                     rst_n,
  aro_in_if.sink                   in_ch,
  aro_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [aro_pkg::UV_W-1:0] cfg_wdata
);
  import aro_pkg::*;

  // control state
  state_t           state_r, state_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [UV_W-1:0]  thr_r;
  logic [LEVELS-1:0] cal_vld_r;
  logic             out_valid_r;

  // calibration table, entry reads as zero until first written
  logic [OHM_W-1:0] cal_ohms_r [LEVELS];
  logic [UV_W-1:0]  cal_uv_r   [LEVELS];

  // pending result and divisor
  status_t           res_status_r, res_status_nxt;
  logic [LVL_FW-1:0] res_level_r, res_level_nxt;
  logic [OHMS_W-1:0] res_ohms_r, res_ohms_nxt;
  logic [UV_W-1:0]   res_uv_r, res_uv_nxt;
  logic [UV_W-1:0]   div_r, div_nxt;

  // output register
  status_t           out_status_r;
  logic [LVL_FW-1:0] out_level_r;
  logic [OHMS_W-1:0] out_ohms_r;
  logic [UV_W-1:0]   out_uv_r;

  // decode of the incoming word
  logic              accept;
  logic              negative;
  logic [UV_W-1:0]   uv;
  logic [OHM_W-1:0]  sel_ohms;
  logic [UV_W-1:0]   sel_uv;
  logic              cal_bad;
  logic [LVL_W-1:0]  cal_idx;
  logic              cal_wr;
  logic              out_load;

  // serial units
  logic              mul_start, mul_done;
  logic [PROD_W-1:0] product;
  logic              div_done;
  logic [PROD_W-1:0] quotient;

  assign accept   = in_ch.valid && in_ch.ready;
  assign negative = in_ch.sample_uv[SAMPLE_W-1];
  // negative readings clamp to zero
  assign uv       = negative ? '0 : in_ch.sample_uv[UV_W-1:0];
  assign sel_ohms = cal_vld_r[level_r] ? cal_ohms_r[level_r] : '0;
  assign sel_uv   = cal_vld_r[level_r] ? cal_uv_r[level_r] : '0;
  assign cal_bad  = ({1'b0, in_ch.cal_level} >= (LVL_FW + 1)'(LEVELS));
  assign cal_idx  = in_ch.cal_level[LVL_W-1:0];
  assign cal_wr   = accept && in_ch.mode && !cal_bad && !in_ch.sample_error &&
                    !in_ch.sample_overrange && !negative;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    level_nxt      = level_r;
    res_status_nxt = res_status_r;
    res_level_nxt  = res_level_r;
    res_ohms_nxt   = res_ohms_r;
    res_uv_nxt     = res_uv_r;
    div_nxt        = div_r;
    mul_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_DONE;
          res_ohms_nxt = '0;
          res_uv_nxt   = '0;
          if (in_ch.mode) begin
            // calibration: checks in priority order, store only when all pass
            res_level_nxt = in_ch.cal_level;
            if (cal_bad)                     res_status_nxt = ST_BAD;
            else if (in_ch.sample_error)     res_status_nxt = ST_CONV;
            else if (in_ch.sample_overrange) res_status_nxt = ST_BAD;
            else if (negative)               res_status_nxt = ST_NEG;
            else begin
              res_status_nxt = ST_OK;
              res_uv_nxt     = uv;
            end
          end else begin
            res_level_nxt = LVL_FW'(level_r);
            if (in_ch.sample_error) begin
              level_nxt      = '0;
              res_status_nxt = ST_CONV;
            end else if (in_ch.sample_overrange) begin
              // open circuit reads as maximum resistance
              level_nxt      = '0;
              res_status_nxt = ST_OK;
              res_ohms_nxt   = OHMS_MAX;
            end else if (uv >= thr_r || level_r == LVL_W'(LEVELS - 1)) begin
              level_nxt      = '0;
              res_status_nxt = ST_OK;
              if (sel_uv == '0) begin
                res_ohms_nxt = OHMS_MAX;
              end else begin
                div_nxt   = sel_uv;
                mul_start = 1'b1;
                state_nxt = S_MUL;
              end
            end else begin
              // ask for the next range
              level_nxt      = level_r + 1'b1;
              res_status_nxt = ST_NEXT;
              res_level_nxt  = LVL_FW'(level_r + 1'b1);
            end
          end
        end
      end
      S_MUL: begin
        if (mul_done) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          res_ohms_nxt = OHMS_W'(quotient);
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= '0;
      thr_r       <= THR_RESET;
      cal_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      if (cal_wr) cal_vld_r[cal_idx] <= 1'b1;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_level_r  <= res_level_nxt;
    res_ohms_r   <= res_ohms_nxt;
    res_uv_r     <= res_uv_nxt;
    div_r        <= div_nxt;
    if (cal_wr) begin
      cal_ohms_r[cal_idx] <= in_ch.ref_ohms;
      cal_uv_r[cal_idx]   <= uv;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_level_r  <= res_level_r;
      out_ohms_r   <= res_ohms_r;
      out_uv_r     <= res_uv_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.range_level = out_level_r;
  assign out_ch.ohms        = out_ohms_r;
  assign out_ch.stored_uv   = out_uv_r;

  // reference ohms times reading, then divided by the calibration reading
  aro_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (sel_ohms),
    .b       (uv),
    .done    (mul_done),
    .product (product)
  );

  aro_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mul_done),
    .dividend (product),
    .divisor  (div_r),
    .done     (div_done),
    .quotient (quotient)
  );

`ifndef SYNTH
  // multiplier finishes only while the sequencer waits for it
  a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier done outside multiply phase");

  // divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider done outside divide phase");

  // range walk never leaves the calibrated levels
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_W'(LEVELS - 1))
    else $error("range level out of bounds");

  // a queued result that is not taken keeps the finished word waiting
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ch.ready) |=> state_r == S_DONE)
    else $error("result dropped while output stalled");
`endif

endmodule

### hw/rtl/aro_mul.sv
// aro_mul: bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on aro_pkg
module aro_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [aro_pkg::OHM_W-1:0]  a,
  input  logic [aro_pkg::UV_W-1:0]   b,
  output logic                       done,
  output logic [aro_pkg::PROD_W-1:0] product
);
  import aro_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [MCNT_W-1:0]   cnt_r;
  logic [OHM_W-1:0]    a_r;
  logic [PROD_W:0]     p_r;    // upper sum with carry, lower multiplier bits
  logic [OHM_W:0]      sum;

  // add multiplicand into the upper half when the current low bit is set
  assign sum = p_r[PROD_W:UV_W] + (p_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MCNT_W'(UV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{(OHM_W + 1){1'b0}}, b};
    end else if (busy_r) begin
      p_r <= {1'b0, sum, p_r[UV_W-1:1]};
    end
  end

  assign done    = done_r;
  assign product = p_r[PROD_W-1:0];

endmodule

### hw/rtl/aro_div.sv
// aro_div: restoring bit-serial divider, one quotient bit per cycle
// depends on aro_pkg
module aro_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [aro_pkg::PROD_W-1:0] dividend,
  input  logic [aro_pkg::UV_W-1:0]   divisor,
  output logic                       done,
  output logic [aro_pkg::PROD_W-1:0] quotient
);
  import aro_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [PROD_W-1:0] q_r;    // dividend shifts out the top, quotient in the bottom
  logic [UV_W-1:0]   rem_r;
  logic [UV_W-1:0]   d_r;
  logic [UV_W:0]     r2;
  logic [UV_W:0]     diff;
  logic              ge;

  assign r2   = {rem_r, q_r[PROD_W-1]};
  assign diff = r2 - {1'b0, d_r};
  assign ge   = (r2 >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits in the low bits
      rem_r <= ge ? diff[UV_W-1:0] : r2[UV_W-1:0];
      q_r   <= {q_r[PROD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### sim/tb_autorange_ohmmeter_calibrated.sv
// tb_autorange_ohmmeter_calibrated: self-checking bench for the autoranging ohmmeter,
// directed table then random range walks and calibrations under random flow control
// depends on aro_pkg, aro_if and the autorange_ohmmeter_calibrated rtl
module tb_autorange_ohmmeter_calibrated;
  timeunit 1ns;
  timeprecision 1ps;
  import aro_pkg::*;

  localparam logic MODE_MEAS = 1'b0;   // measurement reading at the current level
  localparam logic MODE_CAL  = 1'b1;   // calibration reading for cal_level

  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 150;
  localparam int DIRECTED_ROWS = 25;
  localparam int LONG_HOLD     = 300;  // receiver back-pressure stretch, in cycles
  localparam int HOLD_AFTER    = 300;  // input words accepted before that stretch
  localparam int SETTLE        = 4;    // cycles before a threshold write
  localparam int TAIL          = 100;  // run-out, longer than the multiply and divide path
  localparam int STALL_LIMIT   = 4000; // cycles with no handshake anywhere

  typedef struct packed {
    logic                mode;
    logic [SAMPLE_W-1:0] sample_uv;
    logic                over;
    logic                err;
    logic [LVL_FW-1:0]   cal_level;
    logic [OHM_W-1:0]    ref_ohms;
  } reading_t;

  typedef struct packed {
    status_t           status;
    logic [LVL_FW-1:0] range_level;
    logic [OHMS_W-1:0] ohms;
    logic [UV_W-1:0]   stored_uv;
  } meter_result_t;

  typedef struct packed {
    reading_t      word;
    logic          known;    // expected result typed in below
    meter_result_t result;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [UV_W-1:0] cfg_wdata;

  aro_in_if  in_ch ();
  aro_out_if out_ch ();

  autorange_ohmmeter_calibrated dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the block: threshold, range walk position and calibration table
  logic [UV_W-1:0]   threshold;
  logic [LVL_FW-1:0] walk_level;
  logic [OHM_W-1:0]  cal_ohms [LEVELS];
  logic [UV_W-1:0]   cal_uv   [LEVELS];

  meter_result_t expected_q [$];
  int unsigned   errors;
  int unsigned   words_accepted;
  int unsigned   stalled_cycles;
  bit            steady_phase;   // no idling on either side
  bit            long_hold_done;

  // directed words; the tables start empty and the threshold is at its reset value
  plan_row_t directed_plan [DIRECTED_ROWS] = '{
    // measurement conversion error and over-range on a fresh walk
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b1, 3'd0, 31'd0},
      1'b1, '{ST_CONV, 3'd0, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd500,     1'b1, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_OK,   3'd0, OHMS_MAX, 23'd0}},
    // full-scale reading, level 0 never calibrated: zero divisor saturates
    '{'{MODE_MEAS, 24'h7FFFFF,  1'b0, 1'b0, 3'd7, 31'h7FFFFFFF},
      1'b1, '{ST_OK,   3'd0, OHMS_MAX, 23'd0}},
    // calibration failures: level check wins over error and over-range
    '{'{MODE_CAL,  24'd1000,    1'b1, 1'b1, 3'd7, 31'd77},
      1'b1, '{ST_BAD,  3'd7, 63'd0, 23'd0}},
    '{'{MODE_CAL,  24'd1000,    1'b0, 1'b0, 3'd5, 31'd77},
      1'b1, '{ST_BAD,  3'd5, 63'd0, 23'd0}},
    '{'{MODE_CAL,  24'd1000,    1'b0, 1'b1, 3'd0, 31'd77},
      1'b1, '{ST_CONV, 3'd0, 63'd0, 23'd0}},
    '{'{MODE_CAL,  24'd1000,    1'b1, 1'b0, 3'd0, 31'd77},
      1'b1, '{ST_BAD,  3'd0, 63'd0, 23'd0}},
    '{'{MODE_CAL,  24'hFFFFFF,  1'b0, 1'b0, 3'd0, 31'd77},
      1'b1, '{ST_NEG,  3'd0, 63'd0, 23'd0}},
    '{'{MODE_CAL,  24'h800000,  1'b1, 1'b1, 3'd0, 31'd77},
      1'b1, '{ST_CONV, 3'd0, 63'd0, 23'd0}},
    // fill every level, extremes on level 0 and a zero divisor on level 2
    '{'{MODE_CAL,  24'h7FFFFF,  1'b0, 1'b0, 3'd0, 31'h7FFFFFFF},
      1'b1, '{ST_OK,   3'd0, 63'd0, 23'h7FFFFF}},
    '{'{MODE_CAL,  24'd100000,  1'b0, 1'b0, 3'd1, 31'd1000},
      1'b1, '{ST_OK,   3'd1, 63'd0, 23'd100000}},
    '{'{MODE_CAL,  24'd0,       1'b0, 1'b0, 3'd2, 31'd0},
      1'b1, '{ST_OK,   3'd2, 63'd0, 23'd0}},
    '{'{MODE_CAL,  24'd500000,  1'b0, 1'b0, 3'd3, 31'd12345},
      1'b1, '{ST_OK,   3'd3, 63'd0, 23'd500000}},
    '{'{MODE_CAL,  24'd1,       1'b0, 1'b0, 3'd4, 31'd1},
      1'b1, '{ST_OK,   3'd4, 63'd0, 23'd1}},
    // largest product through the divider
    '{'{MODE_MEAS, 24'h7FFFFF,  1'b0, 1'b0, 3'd0, 31'd0},
      1'b0, '{ST_OK,   3'd0, 63'd0, 23'd0}},
    // negative clamps to zero and climbs, one below threshold climbs again
    '{'{MODE_MEAS, 24'h800000,  1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd1, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd124999,  1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd2, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd200000,  1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_OK,   3'd2, OHMS_MAX, 23'd0}},
    // exactly at threshold on level 1
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd1, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd125000,  1'b0, 1'b0, 3'd0, 31'd0},
      1'b0, '{ST_OK,   3'd0, 63'd0, 23'd0}},
    // full walk to the last level, which accepts any reading
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd1, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd2, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd3, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b0, 3'd0, 31'd0},
      1'b1, '{ST_NEXT, 3'd4, 63'd0, 23'd0}},
    '{'{MODE_MEAS, 24'd0,       1'b0, 1'b0, 3'd0, 31'd0},
      1'b0, '{ST_OK,   3'd0, 63'd0, 23'd0}}
  };

  // 8 ns clock, low first so the first rising edge falls inside reset
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly no gap, some short, a few long; never a gap in the steady phase
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (steady_phase || p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // expected result of one accepted word; updates the shadow state
  function automatic meter_result_t predict_reading(reading_t r);
    meter_result_t     res;
    logic              neg;
    logic [UV_W-1:0]   uv;
    logic [LVL_FW-1:0] lvl;
    longint unsigned   prod;
    res.status      = ST_OK;
    res.range_level = '0;
    res.ohms        = '0;
    res.stored_uv   = '0;
    neg = r.sample_uv[SAMPLE_W-1];
    uv  = neg ? '0 : r.sample_uv[UV_W-1:0];
    if (r.mode == MODE_CAL) begin
      res.range_level = r.cal_level;
      if (r.cal_level >= LEVELS) res.status = ST_BAD;
      else if (r.err)            res.status = ST_CONV;
      else if (r.over)           res.status = ST_BAD;
      else if (neg)              res.status = ST_NEG;
      else begin
        // walk position is left alone by a calibration
        cal_ohms[r.cal_level] = r.ref_ohms;
        cal_uv[r.cal_level]   = uv;
        res.stored_uv         = uv;
      end
    end else begin
      lvl = (walk_level >= LEVELS) ? LVL_FW'(LEVELS - 1) : walk_level;
      res.range_level = lvl;
      if (r.err) begin
        res.status = ST_CONV;
        walk_level = '0;
      end else if (r.over) begin
        res.ohms   = OHMS_MAX;
        walk_level = '0;
      end else if (uv >= threshold || lvl == LEVELS - 1) begin
        if (cal_uv[lvl] == '0) begin
          res.ohms = OHMS_MAX;
        end else begin
          prod     = 64'(cal_ohms[lvl]) * 64'(uv);
          res.ohms = OHMS_W'(prod / 64'(cal_uv[lvl]));
        end
        walk_level = '0;
      end else begin
        walk_level      = lvl + 1'b1;
        res.status      = ST_NEXT;
        res.range_level = lvl + 1'b1;
      end
    end
    return res;
  endfunction

  // measurement words aimed around the threshold so walks climb and finish,
  // with calibrations, errors and raw noise mixed in
  function automatic reading_t random_reading();
    reading_t    r;
    int unsigned pick;
    int unsigned thr;
    pick = $urandom_range(99);
    thr  = threshold;
    r.mode      = MODE_MEAS;
    r.sample_uv = SAMPLE_W'($urandom);
    r.over      = ($urandom_range(99) < 4);
    r.err       = ($urandom_range(99) < 4);
    r.cal_level = LVL_FW'($urandom);
    r.ref_ohms  = OHM_W'($urandom);
    if (pick < 10) begin
      r.mode = MODE_CAL;
      if ($urandom_range(99) < 80) r.cal_level = LVL_FW'($urandom_range(LEVELS - 1));
      if ($urandom_range(99) < 75) r.sample_uv = {1'b0, UV_W'($urandom)};
    end else if (pick < 55 && thr > 0) begin
      r.sample_uv = {1'b0, UV_W'($urandom_range(thr - 1, 0))};
    end else if (pick < 85) begin
      r.sample_uv = {1'b0, UV_W'($urandom_range(8388607, thr))};
    end else if (pick < 92) begin
      r.sample_uv = {1'b1, UV_W'($urandom)};
    end
    return r;
  endfunction

  // offer one word, predict it on acceptance, then idle the input for a random gap, which may be none
  task automatic send_reading(input reading_t r, input logic known,
                              input meter_result_t typed);
    meter_result_t want;
    int unsigned   gap;
    @(negedge clk);
    in_ch.mode             <= r.mode;
    in_ch.sample_uv        <= r.sample_uv;
    in_ch.sample_overrange <= r.over;
    in_ch.sample_error     <= r.err;
    in_ch.cal_level        <= r.cal_level;
    in_ch.ref_ohms         <= r.ref_ohms;
    in_ch.valid            <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    want = predict_reading(r);
    expected_q.push_back(known ? typed : want);
    words_accepted++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // threshold writes only happen with the block idle
  task automatic write_threshold(input logic [UV_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    threshold = value;
  endtask

  // well-formed calibration of every level, now and then with a zero reading
  task automatic calibrate_levels();
    reading_t      r;
    meter_result_t none;
    none = '0;
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      r.mode      = MODE_CAL;
      r.over      = 1'b0;
      r.err       = 1'b0;
      r.cal_level = LVL_FW'(lvl);
      r.ref_ohms  = ($urandom_range(99) < 50) ? OHM_W'($urandom_range(100000, 1))
                                              : OHM_W'($urandom);
      r.sample_uv = ($urandom_range(99) < 5) ? '0
                                             : {1'b0, UV_W'($urandom_range(8388607, 1))};
      send_reading(r, 1'b0, none);
    end
  endtask

  // result check: oldest expectation against each accepted result word
  always @(posedge clk) begin : result_check
    meter_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: status %0d level %0d",
               out_ch.status, out_ch.range_level);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.range_level !== want.range_level) begin
          $error("range_level: expected %0d, got %0d", want.range_level,
                 out_ch.range_level);
          errors++;
        end
        if (out_ch.ohms !== want.ohms) begin
          $error("ohms: expected %0d, got %0d", want.ohms, out_ch.ohms);
          errors++;
        end
        if (out_ch.stored_uv !== want.stored_uv) begin
          $error("stored_uv: expected %0d, got %0d", want.stored_uv, out_ch.stored_uv);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake or register write
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("autorange_ohmmeter_calibrated: mismatch");
      $finish;
    end
  end

  // result receiver: random ready, plus one long hold-off while words keep coming
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && words_accepted >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    reading_t      r;
    meter_result_t none;
    logic [UV_W-1:0] thr_pick;
    none = '0;
    errors         = 0;
    words_accepted = 0;
    stalled_cycles = 0;
    steady_phase   = 1'b0;
    long_hold_done = 1'b0;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_ch.valid            = 1'b0;
    in_ch.mode             = MODE_MEAS;
    in_ch.sample_uv        = '0;
    in_ch.sample_overrange = 1'b0;
    in_ch.sample_error     = 1'b0;
    in_ch.cal_level        = '0;
    in_ch.ref_ohms         = '0;
    threshold  = THR_RESET;
    walk_level = '0;
    for (int i = 0; i < LEVELS; i++) begin
      cal_ohms[i] = '0;
      cal_uv[i]   = '0;
    end

    // reset held from the start, released at a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table against the reset state
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_reading(directed_plan[i].word, directed_plan[i].known, directed_plan[i].result);

    // random phases, each under its own threshold; zero and full scale first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       thr_pick = '0;
        1:       thr_pick = '1;
        2:       thr_pick = THR_RESET;
        3:       thr_pick = UV_W'($urandom_range(2000, 1));
        4:       thr_pick = UV_W'($urandom);
        default: thr_pick = UV_W'($urandom_range(400000, 100000));
      endcase
      write_threshold(thr_pick);
      steady_phase = (ph == 2);
      calibrate_levels();
      for (int n = 0; n < PHASE_WORDS - LEVELS; n++) begin
        r = random_reading();
        send_reading(r, 1'b0, none);
      end
    end
    steady_phase = 1'b0;

    drain_results();
    repeat (TAIL) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("autorange_ohmmeter_calibrated: match");
    else
      $display("autorange_ohmmeter_calibrated: mismatch");
    $finish;
  end

endmodule
